### design/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// types and byte codes shared by the command line tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned KindW = 3;
	localparam int unsigned ErrW  = 3;

	localparam int unsigned InDataW  = 8;
	localparam int unsigned OutDataW = 16;
	localparam int unsigned OutUserW = 5;

	localparam logic [KindW-1:0] KIND_NONE  = 3'd0;
	localparam logic [KindW-1:0] KIND_NAME  = 3'd1;
	localparam logic [KindW-1:0] KIND_INT   = 3'd2;
	localparam logic [KindW-1:0] KIND_FLOAT = 3'd3;
	localparam logic [KindW-1:0] KIND_STR   = 3'd4;

	localparam logic [ErrW-1:0] ERR_NONE     = 3'd0;
	localparam logic [ErrW-1:0] ERR_SPACE    = 3'd1;
	localparam logic [ErrW-1:0] ERR_QUOTE    = 3'd2;
	localparam logic [ErrW-1:0] ERR_BYTE     = 3'd3;
	localparam logic [ErrW-1:0] ERR_UNCLOSED = 3'd4;

	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_DASH  = 8'h2d;
	localparam logic [CharW-1:0] CH_DOT   = 8'h2e;
	localparam logic [CharW-1:0] CH_QUOTE = 8'h22;
	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;
	localparam logic [CharW-1:0] CH_PRLO  = 8'd32;
	localparam logic [CharW-1:0] CH_PRHI  = 8'd126;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic             in_quotes;
		logic             has_text;
		logic [ErrW-1:0]  err;
	} tok_state_t;

	typedef struct packed {
		logic [CharW-1:0] char_out;
		logic             append_flag;
		logic             token_done;
		logic [KindW-1:0] token_kind;
		logic             command_done;
		logic [ErrW-1:0]  error_code;
	} tok_result_t;

	localparam tok_state_t STATE_RESET = '{
		kind:      KIND_NAME,
		in_quotes: 1'b0,
		has_text:  1'b0,
		err:       ERR_NONE
	};

endpackage

`default_nettype wire

### design/clt_step.sv
// ----------------------------------------------------------------------------
// clt_step
// classifies one command byte or end marker against the tokenizer state
// ----------------------------------------------------------------------------
`default_nettype none

module clt_step (
	input  wire logic [clt_pkg::CharW-1:0] char_in,
	input  wire logic                      end_mark,
	input  wire clt_pkg::tok_state_t       cur,
	output clt_pkg::tok_state_t            nxt,
	output clt_pkg::tok_result_t           res
);
	import clt_pkg::*;

	logic is_space, is_digit, is_dash, is_dot, is_quote, is_print;

	assign is_space = (char_in == CH_SPACE);
	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign is_dash  = (char_in == CH_DASH);
	assign is_dot   = (char_in == CH_DOT);
	assign is_quote = (char_in == CH_QUOTE);
	assign is_print = (char_in >= CH_PRLO) && (char_in <= CH_PRHI);

	always_comb begin
		nxt = cur;
		res = '0;
		if (end_mark) begin
			if (cur.err != ERR_NONE) begin
				res.error_code = cur.err;
			end else if (cur.in_quotes) begin
				res.error_code = ERR_UNCLOSED;
			end else if (cur.kind != KIND_NONE && cur.has_text) begin
				res.token_done = 1'b1;
				res.token_kind = cur.kind;
			end
			res.command_done = 1'b1;
			nxt = STATE_RESET;
		end else if (cur.err != ERR_NONE) begin
			res.error_code = cur.err;
		end else if (is_space) begin
			if (cur.in_quotes) begin
				res.append_flag = 1'b1;
				res.char_out    = char_in;
				nxt.has_text    = 1'b1;
			end else if (cur.kind == KIND_NONE || !cur.has_text) begin
				res.error_code = ERR_SPACE;
			end else begin
				res.token_done = 1'b1;
				res.token_kind = cur.kind;
				nxt.kind       = KIND_NONE;
				nxt.has_text   = 1'b0;
			end
		end else if (is_digit || is_dash) begin
			if (cur.kind == KIND_NONE) begin
				nxt.kind = KIND_INT;
			end else if (is_dash && cur.kind != KIND_NAME) begin
				nxt.kind = KIND_STR;
			end
			res.append_flag = 1'b1;
			res.char_out    = char_in;
			nxt.has_text    = 1'b1;
		end else if (is_dot) begin
			if (cur.kind == KIND_INT || cur.kind == KIND_NONE) begin
				nxt.kind = KIND_FLOAT;
			end
			res.append_flag = 1'b1;
			res.char_out    = char_in;
			nxt.has_text    = 1'b1;
		end else if (is_quote) begin
			if (!cur.in_quotes) begin
				if (cur.kind != KIND_NONE) begin
					res.error_code = ERR_QUOTE;
				end else begin
					nxt.kind      = KIND_STR;
					nxt.in_quotes = 1'b1;
				end
			end else begin
				res.token_done = 1'b1;
				res.token_kind = cur.kind;
				nxt.kind       = KIND_NONE;
				nxt.has_text   = 1'b0;
				nxt.in_quotes  = 1'b0;
			end
		end else if (is_print) begin
			if (cur.kind != KIND_NAME) begin
				nxt.kind = KIND_STR;
			end
			res.append_flag = 1'b1;
			res.char_out    = char_in;
			nxt.has_text    = 1'b1;
		end else begin
			res.error_code = ERR_BYTE;
		end
		if (!end_mark && res.error_code != ERR_NONE) begin
			nxt.err = res.error_code;
		end
	end

endmodule

`default_nettype wire

### design/command_line_tokenizer_core.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_core
// splits a console command byte stream into classified tokens
// ----------------------------------------------------------------------------
// One command byte per transfer on the slave side, tlast marking the end of
// the command (that transfer carries no byte). Exactly one result transfer
// leaves per input transfer, in order. A transfer is taken every cycle while
// the master side keeps up; each byte passes the input register and then
// the result register, and the tokenizer state register closes its loop
// within the single classification step between them. An output register
// and the input register let a new byte enter while a result waits.
`default_nettype none

module command_line_tokenizer_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [clt_pkg::InDataW-1:0]        s_tdata,  // char_in[7:0]
	input  wire logic                               s_tlast,  // end_mark
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      logic [clt_pkg::OutDataW-1:0]       m_tdata,  // char_out[7:0], error_code[10:8], zero
	output      logic [clt_pkg::OutUserW-1:0]       m_tuser,  // append_flag, token_done, token_kind[4:2]
	output      logic                               m_tlast   // command_done
);
	import clt_pkg::*;

	logic               valid_s1, valid_s2;
	logic [CharW-1:0]   char_s1;
	logic               end_s1;
	tok_result_t        res_s2;
	tok_state_t         state_q, state_nxt;
	tok_result_t        res_nxt;
	logic               ready_s2, ready_s1, adv;

	assign ready_s2 = !valid_s2 || m_tready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign adv      = valid_s1 && ready_s2;
	assign s_tready = ready_s1;

	clt_step u_step (
		.char_in  (char_s1),
		.end_mark (end_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			char_s1 <= s_tdata[CharW-1:0];
			end_s1  <= s_tlast;
		end
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutDataW - CharW - ErrW){1'b0}}, res_s2.error_code, res_s2.char_out};
	assign m_tuser  = {res_s2.token_kind, res_s2.token_done, res_s2.append_flag};
	assign m_tlast  = res_s2.command_done;

endmodule

`default_nettype wire

### design/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// port level checks on the command line tokenizer result stream
// ----------------------------------------------------------------------------
`default_nettype none

module clt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [4:0]  m_tuser,
	input wire logic        m_tlast
);

	// stalled result transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[4:2] != 3'd0 && m_tdata[10:8] == 3'd0)
		else $error("completed token without kind or with error");

	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[10:8] == 3'd0 && !m_tlast && !m_tuser[1])
		else $error("append together with error, end or completion");

	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0 && m_tdata[15:11] == 5'd0)
		else $error("byte shown without append");

endmodule

bind command_line_tokenizer_core clt_checker u_clt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
